### rtl/tmb_pkg.sv
// Shared types and codes for the periodic timer bank.
// Used by the top level and the update stage of the bank and by its port checker.
package tmb_pkg;

  localparam int NUM_TIMERS_DEF  = 16;
  localparam int COUNT_WIDTH_DEF = 32;

  localparam logic [4:0] TIMERS_IN_USE_RESET = 5'd16;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_STOP    = 2'd1,
    OP_COMPARE = 2'd2,
    OP_TICK    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SWEEP  = 2'd1,
    ST_FINISH = 2'd2
  } fsm_t;

  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_INVALID     = 2'd1;
  localparam logic [1:0] STATUS_NOT_RUNNING = 2'd2;

  localparam logic [1:0] ORDER_LESS    = 2'b11;
  localparam logic [1:0] ORDER_EQUAL   = 2'b00;
  localparam logic [1:0] ORDER_GREATER = 2'b01;

  localparam logic KIND_RESPONSE = 1'b0;
  localparam logic KIND_EVENT    = 1'b1;

  typedef struct packed {
    op_t  op;
    logic cmd_hit;
    logic tick_en;
  } step_ctl_t;

endpackage

### rtl/periodic_timer_bank.sv
// Periodic timer bank: top level with the ring of timer cells, sweep control
// and output register. Depends on tmb_pkg, tmb_cell and tmb_step.
//
// Items are taken one at a time; each is accepted, swept past every entry and
// finished before the bank is idle again. The entries sit in a ring of cells
// that rotates one place per cycle while the sweep advances, through a single
// update stage, so each item visits every entry once. The sweep pauses while
// a second expiry event waits behind a full output register; the finishing
// state waits for a free output unless a tick has no event left. A command
// gives one response; a tick gives one event per notifying expiry, in
// ascending timer order, the final one flagged by tlast, or nothing.
module periodic_timer_bank #(
  parameter int NUM_TIMERS  = tmb_pkg::NUM_TIMERS_DEF,
  parameter int COUNT_WIDTH = tmb_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data,      // timers_in_use
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,  // timer_index, other_index, delay_ticks,
                                     // repeat_count, notify_enable, zero fill
  input  logic [1:0]  s_axis_tuser,  // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // status, order, expired_timer, zero fill
  output logic [0:0]  m_axis_tuser,  // kind
  output logic        m_axis_tlast
);
  import tmb_pkg::*;

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

  logic [4:0]  timers_in_use;
  logic [8:0]  n_active;
  fsm_t        state;
  fsm_t        state_next;
  logic [IDX_W-1:0] head;
  op_t         op_r;
  logic [7:0]  ta_r;
  logic [7:0]  tb_r;
  logic [31:0] delay_r;
  logic [31:0] repeat_r;
  logic        notify_r;
  logic        cap_a_run;
  logic        cap_b_run;
  logic [COUNT_WIDTH-1:0] cap_a_cnt;
  logic [COUNT_WIDTH-1:0] cap_b_cnt;
  logic        pend_valid;
  logic [7:0]  pend_idx;
  logic        a_ok;
  logic        b_ok;
  logic        out_free;
  logic        advance;
  logic        load_out;
  logic        out_kind;
  logic [1:0]  out_status;
  logic [1:0]  out_order;
  logic [7:0]  out_idx;
  logic        out_last;
  logic        emit;
  logic        accept;
  step_ctl_t   ctl;

  logic                   q_pending [NUM_TIMERS];
  logic                   q_running [NUM_TIMERS];
  logic [COUNT_WIDTH-1:0] q_count   [NUM_TIMERS];
  logic [COUNT_WIDTH-1:0] q_reload  [NUM_TIMERS];
  logic [COUNT_WIDTH-1:0] q_rtotal  [NUM_TIMERS];
  logic [COUNT_WIDTH-1:0] q_rleft   [NUM_TIMERS];
  logic                   q_notify  [NUM_TIMERS];
  logic                   d_pending [NUM_TIMERS];
  logic                   d_running [NUM_TIMERS];
  logic [COUNT_WIDTH-1:0] d_count   [NUM_TIMERS];
  logic [COUNT_WIDTH-1:0] d_reload  [NUM_TIMERS];
  logic [COUNT_WIDTH-1:0] d_rtotal  [NUM_TIMERS];
  logic [COUNT_WIDTH-1:0] d_rleft   [NUM_TIMERS];
  logic                   d_notify  [NUM_TIMERS];

  logic                   nxt_pending;
  logic                   nxt_running;
  logic [COUNT_WIDTH-1:0] nxt_count;
  logic [COUNT_WIDTH-1:0] nxt_reload;
  logic [COUNT_WIDTH-1:0] nxt_rtotal;
  logic [COUNT_WIDTH-1:0] nxt_rleft;
  logic                   nxt_notify;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  assign n_active = (9'(timers_in_use) < 9'(NUM_TIMERS)) ? 9'(timers_in_use)
                                                         : 9'(NUM_TIMERS);
  assign a_ok = 9'(ta_r) < n_active;
  assign b_ok = 9'(tb_r) < n_active;

  assign ctl.op      = op_r;
  assign ctl.cmd_hit = (9'(head) == 9'(ta_r)) && a_ok;
  assign ctl.tick_en = 9'(head) < n_active;

  always_ff @(posedge clk) begin
    if (rst) begin
      timers_in_use <= TIMERS_IN_USE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      timers_in_use <= cfg_data;
    end
  end

  tmb_step #(.COUNT_WIDTH(COUNT_WIDTH)) u_step (
    .ctl          (ctl),
    .delay_ticks  (delay_r),
    .repeat_count (repeat_r),
    .notify_enable(notify_r),
    .cur_pending  (q_pending[0]),
    .cur_running  (q_running[0]),
    .cur_count    (q_count[0]),
    .cur_reload   (q_reload[0]),
    .cur_rtotal   (q_rtotal[0]),
    .cur_rleft    (q_rleft[0]),
    .cur_notify   (q_notify[0]),
    .nxt_pending  (nxt_pending),
    .nxt_running  (nxt_running),
    .nxt_count    (nxt_count),
    .nxt_reload   (nxt_reload),
    .nxt_rtotal   (nxt_rtotal),
    .nxt_rleft    (nxt_rleft),
    .nxt_notify   (nxt_notify),
    .emit         (emit)
  );

  for (genvar j = 0; j < NUM_TIMERS; j++) begin : g_cell
    if (j == NUM_TIMERS - 1) begin : g_tail
      assign d_pending[j] = nxt_pending;
      assign d_running[j] = nxt_running;
      assign d_count[j]   = nxt_count;
      assign d_reload[j]  = nxt_reload;
      assign d_rtotal[j]  = nxt_rtotal;
      assign d_rleft[j]   = nxt_rleft;
      assign d_notify[j]  = nxt_notify;
    end else begin : g_mid
      assign d_pending[j] = q_pending[j+1];
      assign d_running[j] = q_running[j+1];
      assign d_count[j]   = q_count[j+1];
      assign d_reload[j]  = q_reload[j+1];
      assign d_rtotal[j]  = q_rtotal[j+1];
      assign d_rleft[j]   = q_rleft[j+1];
      assign d_notify[j]  = q_notify[j+1];
    end
    tmb_cell #(.COUNT_WIDTH(COUNT_WIDTH)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift_en (advance),
      .d_pending(d_pending[j]),
      .d_running(d_running[j]),
      .d_count  (d_count[j]),
      .d_reload (d_reload[j]),
      .d_rtotal (d_rtotal[j]),
      .d_rleft  (d_rleft[j]),
      .d_notify (d_notify[j]),
      .q_pending(q_pending[j]),
      .q_running(q_running[j]),
      .q_count  (q_count[j]),
      .q_reload (q_reload[j]),
      .q_rtotal (q_rtotal[j]),
      .q_rleft  (q_rleft[j]),
      .q_notify (q_notify[j])
    );
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (advance && (head == LAST_IDX)) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if ((op_r == OP_TICK && !pend_valid) || out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    advance    = 1'b0;
    load_out   = 1'b0;
    out_kind   = KIND_RESPONSE;
    out_status = STATUS_OK;
    out_order  = ORDER_EQUAL;
    out_idx    = '0;
    out_last   = 1'b1;
    case (state)
      ST_SWEEP: begin
        advance = !(emit && pend_valid && !out_free);
        if (advance && emit && pend_valid) begin
          load_out = 1'b1;
          out_kind = KIND_EVENT;
          out_idx  = pend_idx;
          out_last = 1'b0;
        end
      end
      ST_FINISH: begin
        if (op_r == OP_TICK) begin
          if (pend_valid && out_free) begin
            load_out = 1'b1;
            out_kind = KIND_EVENT;
            out_idx  = pend_idx;
          end
        end else if (out_free) begin
          load_out = 1'b1;
          if (!a_ok || (op_r == OP_COMPARE && !b_ok)) begin
            out_status = STATUS_INVALID;
          end else if (op_r == OP_COMPARE) begin
            if (!cap_a_run || !cap_b_run) begin
              out_status = STATUS_NOT_RUNNING;
            end else if (cap_a_cnt < cap_b_cnt) begin
              out_order = ORDER_LESS;
            end else if (cap_a_cnt > cap_b_cnt) begin
              out_order = ORDER_GREATER;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      head       <= '0;
      pend_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        head       <= '0;
        pend_valid <= 1'b0;
      end else if (advance) begin
        head <= (head == LAST_IDX) ? '0 : head + 1'b1;
      end
      if (state == ST_FINISH && load_out) begin
        pend_valid <= 1'b0;
      end else if (advance && emit) begin
        pend_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= op_t'(s_axis_tuser);
      ta_r     <= s_axis_tdata[7:0];
      tb_r     <= s_axis_tdata[15:8];
      delay_r  <= s_axis_tdata[47:16];
      repeat_r <= s_axis_tdata[79:48];
      notify_r <= s_axis_tdata[80];
    end
    if (advance && emit) begin
      pend_idx <= 8'(head);
    end
    if (advance && (9'(head) == 9'(ta_r))) begin
      cap_a_run <= q_running[0];
      cap_a_cnt <= q_count[0];
    end
    if (advance && (9'(head) == 9'(tb_r))) begin
      cap_b_run <= q_running[0];
      cap_b_cnt <= q_count[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_axis_tuser <= out_kind;
      m_axis_tdata <= {4'b0000, out_idx, out_order, out_status};
      m_axis_tlast <= out_last;
    end
  end

endmodule

### rtl/tmb_cell.sv
// One timer entry of the ring: holds the entry and takes its neighbor's on a shift.
// Depends on nothing but the clock and reset.
module tmb_cell #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   shift_en,
  input  logic                   d_pending,
  input  logic                   d_running,
  input  logic [COUNT_WIDTH-1:0] d_count,
  input  logic [COUNT_WIDTH-1:0] d_reload,
  input  logic [COUNT_WIDTH-1:0] d_rtotal,
  input  logic [COUNT_WIDTH-1:0] d_rleft,
  input  logic                   d_notify,
  output logic                   q_pending,
  output logic                   q_running,
  output logic [COUNT_WIDTH-1:0] q_count,
  output logic [COUNT_WIDTH-1:0] q_reload,
  output logic [COUNT_WIDTH-1:0] q_rtotal,
  output logic [COUNT_WIDTH-1:0] q_rleft,
  output logic                   q_notify
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q_pending <= 1'b0;
      q_running <= 1'b0;
      q_count   <= '0;
      q_reload  <= '0;
      q_rtotal  <= '0;
      q_rleft   <= '0;
      q_notify  <= 1'b0;
    end else if (shift_en) begin
      q_pending <= d_pending;
      q_running <= d_running;
      q_count   <= d_count;
      q_reload  <= d_reload;
      q_rtotal  <= d_rtotal;
      q_rleft   <= d_rleft;
      q_notify  <= d_notify;
    end
  end

endmodule

### rtl/tmb_step.sv
// Update stage at the head of the ring: applies start, stop or tick to one entry.
// Depends on tmb_pkg for operation codes and the control struct.
module tmb_step #(
  parameter int COUNT_WIDTH = 32
) (
  input  tmb_pkg::step_ctl_t     ctl,
  input  logic [31:0]            delay_ticks,
  input  logic [31:0]            repeat_count,
  input  logic                   notify_enable,
  input  logic                   cur_pending,
  input  logic                   cur_running,
  input  logic [COUNT_WIDTH-1:0] cur_count,
  input  logic [COUNT_WIDTH-1:0] cur_reload,
  input  logic [COUNT_WIDTH-1:0] cur_rtotal,
  input  logic [COUNT_WIDTH-1:0] cur_rleft,
  input  logic                   cur_notify,
  output logic                   nxt_pending,
  output logic                   nxt_running,
  output logic [COUNT_WIDTH-1:0] nxt_count,
  output logic [COUNT_WIDTH-1:0] nxt_reload,
  output logic [COUNT_WIDTH-1:0] nxt_rtotal,
  output logic [COUNT_WIDTH-1:0] nxt_rleft,
  output logic                   nxt_notify,
  output logic                   emit
);
  import tmb_pkg::*;

  logic [COUNT_WIDTH-1:0] cnt_dec;
  logic [COUNT_WIDTH-1:0] rep_dec;

  assign cnt_dec = (cur_count != '0) ? cur_count - 1'b1 : '0;
  assign rep_dec = (cur_rleft != '0) ? cur_rleft - 1'b1 : '0;

  always_comb begin
    nxt_pending = cur_pending;
    nxt_running = cur_running;
    nxt_count   = cur_count;
    nxt_reload  = cur_reload;
    nxt_rtotal  = cur_rtotal;
    nxt_rleft   = cur_rleft;
    nxt_notify  = cur_notify;
    emit        = 1'b0;
    case (ctl.op)
      OP_START: begin
        if (ctl.cmd_hit) begin
          nxt_reload  = COUNT_WIDTH'(delay_ticks);
          nxt_rtotal  = COUNT_WIDTH'(repeat_count);
          nxt_rleft   = COUNT_WIDTH'(repeat_count);
          nxt_notify  = notify_enable;
          nxt_running = 1'b0;
          nxt_pending = 1'b1;
        end
      end
      OP_STOP: begin
        if (ctl.cmd_hit) begin
          nxt_pending = 1'b0;
          nxt_running = 1'b0;
          nxt_count   = '0;
          nxt_reload  = '0;
          nxt_rtotal  = '0;
          nxt_rleft   = '0;
          nxt_notify  = 1'b0;
        end
      end
      OP_TICK: begin
        if (ctl.tick_en) begin
          if (cur_pending) begin
            nxt_count   = cur_reload;
            nxt_pending = 1'b0;
            nxt_running = 1'b1;
          end else if (cur_running) begin
            nxt_count = cnt_dec;
            if (cnt_dec == '0) begin
              emit = cur_notify;
              if (cur_reload == '0) begin
                nxt_running = 1'b0;
              end else if (cur_rtotal == '0) begin
                nxt_count = cur_reload;
              end else begin
                nxt_rleft = rep_dec;
                if (rep_dec == '0) begin
                  nxt_running = 1'b0;
                end else begin
                  nxt_count = cur_reload;
                end
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/tmb_checker.sv
// Port-level checks for the periodic timer bank, bound to its top level.
// Depends on tmb_pkg for result codes.
module tmb_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  import tmb_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken during a sweep");

  a_response_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser[0] == KIND_RESPONSE) |-> m_axis_tlast)
    else $error("response without last");

  a_event_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser[0] == KIND_EVENT) |->
      (m_axis_tdata[1:0] == STATUS_OK) && (m_axis_tdata[3:2] == ORDER_EQUAL))
    else $error("event carries status or order");

  a_response_index: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser[0] == KIND_RESPONSE) |-> m_axis_tdata[11:4] == 8'd0)
    else $error("response carries a timer index");

endmodule

bind periodic_timer_bank tmb_checker u_tmb_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);
